>>> hw/rtl/rpa_pkg.sv
`default_nettype none

package rpa_pkg;

	localparam int ADDR_W   = 27;
	localparam int GRANT_W  = 26;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [ADDR_W-1:0] KERNEL_END_RESET = 27'h0400000;
	localparam logic [ADDR_W-1:0] PHYS_TOP_RESET   = 27'h4000000;

	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP   = 1'b1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 3'd0,
		ST_RETURNED  = 3'd1,
		ST_STILL_REF = 3'd2,
		ST_OUT_OF_MEM = 3'd3,
		ST_BAD_ADDR  = 3'd4,
		ST_STACK_FULL = 3'd5
	} status_t;

	typedef struct packed {
		logic clear;
		logic issue;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpa_controller.sv
`default_nettype none

module rpa_controller (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rpa_pkg::dp_cmd_t      cmd,
	input  wire rpa_pkg::dp_sts_t sts
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.clear = (state_q == S_CLEAR);
		cmd.issue = (state_q == S_IDLE) && in_valid;
		cmd.exec  = (state_q == S_EXEC) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rpa_datapath.sv
`default_nettype none

module rpa_datapath #(
	parameter int NUM_PAGES  = 16384,
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire rpa_pkg::dp_cmd_t                 cmd,
	output rpa_pkg::dp_sts_t                      sts,
	input  wire logic                             cfg_we,
	input  wire logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rpa_pkg::ADDR_W-1:0]       cfg_data,
	input  wire logic                             command,
	input  wire logic [31:0]                      page_address,
	output logic [rpa_pkg::GRANT_W-1:0]           granted_address,
	output logic [rpa_pkg::STATUS_W-1:0]          status
);

	localparam int IDX_W = $clog2(NUM_PAGES);
	localparam int CNT_W = $clog2(NUM_PAGES + 1);
	localparam int PB_W  = $clog2(PAGE_BYTES);
	localparam int GA_W  = IDX_W + PB_W + rpa_pkg::GRANT_W;
	localparam longint unsigned LIMIT = longint'(NUM_PAGES) * longint'(PAGE_BYTES);

	logic [rpa_pkg::ADDR_W-1:0]  kernel_end_q;
	logic [rpa_pkg::ADDR_W-1:0]  phys_top_q;
	logic [CNT_W-1:0]            free_count_q;
	logic [IDX_W-1:0]            clr_idx_q;

	logic [IDX_W-1:0]            stack_mem [NUM_PAGES];
	logic [rpa_pkg::COUNT_W-1:0] ref_mem   [NUM_PAGES];

	logic                        cmd_s1;
	logic [31:0]                 addr_s1;
	logic [IDX_W-1:0]            stk_rd_q;
	logic [rpa_pkg::COUNT_W-1:0] ref_rd_q;
	logic [rpa_pkg::GRANT_W-1:0] granted_q;
	rpa_pkg::status_t            status_q;

	logic [63:0]                 in_addr_ext;
	logic [63:0]                 s1_addr_ext;
	logic [IDX_W-1:0]            in_idx;
	logic [IDX_W-1:0]            fidx;
	logic [IDX_W-1:0]            pop_addr;
	logic                        bad_addr;
	logic [GA_W-1:0]             grant_full;
	logic [rpa_pkg::COUNT_W-1:0] dec;

	logic                        ref_we;
	logic [IDX_W-1:0]            ref_wa;
	logic [rpa_pkg::COUNT_W-1:0] ref_wd;
	logic                        stk_we;
	logic                        push_req;
	logic [CNT_W-1:0]            fc_next;
	rpa_pkg::status_t            st_next;
	logic [rpa_pkg::GRANT_W-1:0] ga_next;

	assign in_addr_ext = 64'(page_address);
	assign s1_addr_ext = 64'(addr_s1);
	assign in_idx      = in_addr_ext[PB_W +: IDX_W];
	assign fidx        = s1_addr_ext[PB_W +: IDX_W];
	assign pop_addr    = (free_count_q == '0) ? '0 : IDX_W'(free_count_q - CNT_W'(1));
	assign grant_full  = {{rpa_pkg::GRANT_W{1'b0}}, stk_rd_q, {PB_W{1'b0}}};
	assign dec         = ref_rd_q - rpa_pkg::COUNT_W'(1);

	assign bad_addr = (|addr_s1[PB_W-1:0])
		|| (addr_s1 < 32'(kernel_end_q))
		|| (addr_s1 >= 32'(phys_top_q))
		|| (s1_addr_ext >= 64'(LIMIT));

	assign sts.clear_done = (clr_idx_q == IDX_W'(NUM_PAGES - 1));

	always_comb begin
		ref_we   = 1'b0;
		ref_wa   = clr_idx_q;
		ref_wd   = '0;
		stk_we   = 1'b0;
		push_req = 1'b0;
		fc_next  = free_count_q;
		st_next  = rpa_pkg::ST_BAD_ADDR;
		ga_next  = '0;
		if (cmd.clear) begin
			ref_we = 1'b1;
		end
		if (cmd.exec) begin
			if (cmd_s1 == rpa_pkg::CMD_ALLOC) begin
				if (free_count_q == '0) begin
					st_next = rpa_pkg::ST_OUT_OF_MEM;
				end else begin
					fc_next = free_count_q - CNT_W'(1);
					ref_we  = 1'b1;
					ref_wa  = stk_rd_q;
					ref_wd  = rpa_pkg::COUNT_W'(1);
					ga_next = grant_full[rpa_pkg::GRANT_W-1:0];
					st_next = rpa_pkg::ST_ALLOCATED;
				end
			end else if (bad_addr) begin
				st_next = rpa_pkg::ST_BAD_ADDR;
			end else if (ref_rd_q == '0) begin
				push_req = 1'b1;
			end else begin
				ref_we = 1'b1;
				ref_wa = fidx;
				ref_wd = dec;
				if (dec == '0) begin
					push_req = 1'b1;
				end else begin
					st_next = rpa_pkg::ST_STILL_REF;
				end
			end
			if (push_req) begin
				if (free_count_q == CNT_W'(NUM_PAGES)) begin
					st_next = rpa_pkg::ST_STACK_FULL;
				end else begin
					stk_we  = 1'b1;
					fc_next = free_count_q + CNT_W'(1);
					st_next = rpa_pkg::ST_RETURNED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_end_q <= rpa_pkg::KERNEL_END_RESET;
			phys_top_q   <= rpa_pkg::PHYS_TOP_RESET;
			free_count_q <= '0;
			clr_idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rpa_pkg::CFG_KERNEL_END: kernel_end_q <= cfg_data;
					rpa_pkg::CFG_PHYS_TOP:   phys_top_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			free_count_q <= fc_next;
		end
	end

	// count store: one write port, registered read
	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_wa] <= ref_wd;
		end
		if (cmd.issue) begin
			ref_rd_q <= ref_mem[in_idx];
		end
	end

	// free stack
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[IDX_W'(free_count_q)] <= fidx;
		end
		if (cmd.issue) begin
			stk_rd_q <= stack_mem[pop_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			cmd_s1  <= command;
			addr_s1 <= page_address;
		end
		if (cmd.exec) begin
			granted_q <= ga_next;
			status_q  <= st_next;
		end
	end

	assign granted_address = granted_q;
	assign status          = status_q;

endmodule

`default_nettype wire

>>> hw/rtl/refcounted_page_allocator.sv
// A transaction is accepted in the idle state; the count store and free stack are read into
// registers, then one read-modify-write step registers the result. A result not yet taken
// holds that step, and no new transaction is accepted until that step of the last one is done.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the count store, one
// entry per cycle, during which no transaction is accepted.
`default_nettype none

module refcounted_page_allocator #(
	parameter int NUM_PAGES  = 16384,
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rpa_pkg::ADDR_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	input  wire logic [31:0]                   page_address,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rpa_pkg::GRANT_W-1:0]        granted_address,
	output logic [rpa_pkg::STATUS_W-1:0]       status
);

	rpa_pkg::dp_cmd_t dp_cmd;
	rpa_pkg::dp_sts_t dp_sts;

	rpa_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	rpa_datapath #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.sts             (dp_sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.command         (command),
		.page_address    (page_address),
		.granted_address (granted_address),
		.status          (status)
	);

`ifndef SYNTHESIS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.clear |-> !in_ready)
		else $error("transaction accepted during clearing pass");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction accepted while one is in flight");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.exec |-> (!out_valid || out_ready))
		else $error("result register overwritten before it was taken");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != rpa_pkg::ST_ALLOCATED)) |-> (granted_address == '0))
		else $error("nonzero address on a result that is not an allocation");
`endif

endmodule

`default_nettype wire

>>> tb/tb_refcounted_page_allocator.sv
`timescale 1ns / 100ps

module tb_refcounted_page_allocator;

	import rpa_pkg::*;

	localparam int NUM_PAGES  = 16384;
	localparam int PAGE_BYTES = 4096;
	localparam longint unsigned MEM_BYTES = longint'(NUM_PAGES) * PAGE_BYTES;
	localparam logic [31:0] OFFSET_MASK = PAGE_BYTES - 1;
	localparam int IDLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic        cmd;
		logic [31:0] addr;
	} page_req_t;

	typedef struct packed {
		logic [GRANT_W-1:0] grant;
		status_t            st;
	} page_outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 command = 1'b0;
	logic [31:0]          page_address = '0;
	logic                 out_ready = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic [GRANT_W-1:0]   granted_address;
	logic [STATUS_W-1:0]  status;

	refcounted_page_allocator #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.page_address   (page_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_address(granted_address),
		.status         (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	page_req_t     request_q[$];
	page_outcome_t outcome_q[$];
	logic [31:0]   page_pool[$];

	logic [13:0]       free_stack [NUM_PAGES];
	logic [7:0]        ref_cnt [NUM_PAGES];
	int unsigned       free_depth = 0;
	logic [ADDR_W-1:0] kernel_end_r = KERNEL_END_RESET;
	logic [ADDR_W-1:0] phys_top_r = PHYS_TOP_RESET;

	int fail_cnt = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int calm_left[2] = '{0, 0};
	int send_gap = 0;
	int rx_wait = 0;
	int hold_left = 0;
	bit req_taken = 1'b0;
	bit rsp_taken = 1'b0;

	function automatic status_t push_free(logic [13:0] idx);
		if (free_depth >= NUM_PAGES)
			return ST_STACK_FULL;
		free_stack[free_depth] = idx;
		free_depth++;
		return ST_RETURNED;
	endfunction

	function automatic void predict_outcome(logic cmd, logic [31:0] addr);
		page_outcome_t r;
		logic [13:0]   idx;
		r.grant = '0;
		if (cmd == CMD_ALLOC) begin
			if (free_depth == 0) begin
				r.st = ST_OUT_OF_MEM;
			end else begin
				free_depth--;
				idx = free_stack[free_depth];
				ref_cnt[idx] = 8'd1;
				r.grant = GRANT_W'(int'(idx) * PAGE_BYTES);
				r.st = ST_ALLOCATED;
			end
		end else if ((addr & OFFSET_MASK) != 0 || addr < 32'(kernel_end_r) ||
				addr >= 32'(phys_top_r) || longint'(addr) >= MEM_BYTES) begin
			r.st = ST_BAD_ADDR;
		end else begin
			idx = 14'(addr / PAGE_BYTES);
			if (ref_cnt[idx] == 0) begin
				r.st = push_free(idx);
			end else begin
				ref_cnt[idx]--;
				r.st = (ref_cnt[idx] == 0) ? push_free(idx) : ST_STILL_REF;
			end
		end
		outcome_q.push_back(r);
	endfunction

	function automatic int draw_gap(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left[side] = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_outcome(command, page_address);
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : drive_requests
		logic      v;
		page_req_t item;
		v = in_valid;
		if (req_taken) begin
			req_taken = 1'b0;
			v = 1'b0;
			send_gap = draw_gap(0);
		end
		if (!v) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (request_q.size() > 0) begin
				item = request_q.pop_front();
				command <= item.cmd;
				page_address <= item.addr;
				v = 1'b1;
			end
		end
		in_valid <= v;
	end

	// result monitor
	always @(posedge clk) begin : check_results
		page_outcome_t exp;
		if (out_valid && out_ready) begin
			results_seen++;
			rsp_taken = 1'b1;
			if (outcome_q.size() == 0) begin
				$error("unexpected transaction: granted_address %h status %0d",
					granted_address, status);
				fail_cnt++;
			end else begin
				exp = outcome_q.pop_front();
				if (granted_address !== exp.grant) begin
					$error("granted_address: expected %h, actual %h", exp.grant, granted_address);
					fail_cnt++;
				end
				if (status !== exp.st) begin
					$error("status: expected %0d, actual %0d", exp.st, status);
					fail_cnt++;
				end
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		logic r;
		if (rsp_taken) begin
			rsp_taken = 1'b0;
			rx_wait = draw_gap(1);
			if (results_seen % 400 == 200 && results_seen < 2000)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			r = 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			r = 1'b0;
		end else begin
			r = 1'b1;
		end
		out_ready <= r;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send(logic cmd, logic [31:0] addr);
		page_req_t item;
		item.cmd = cmd;
		item.addr = addr;
		request_q.push_back(item);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (request_q.size() != 0 || in_valid || outcome_q.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KERNEL_END)
			kernel_end_r = val;
		else
			phys_top_r = val;
	endtask

	function automatic void refresh_pool();
		int lo;
		int hi;
		page_pool.delete();
		lo = (int'(kernel_end_r) + PAGE_BYTES - 1) / PAGE_BYTES;
		hi = (int'(phys_top_r) + PAGE_BYTES - 1) / PAGE_BYTES;
		if (hi > NUM_PAGES)
			hi = NUM_PAGES;
		if (lo < hi) begin
			page_pool.push_back(lo * PAGE_BYTES);
			page_pool.push_back((hi - 1) * PAGE_BYTES);
			repeat (10)
				page_pool.push_back($urandom_range(lo, hi - 1) * PAGE_BYTES);
		end else begin
			repeat (12)
				page_pool.push_back($urandom_range(0, NUM_PAGES - 1) * PAGE_BYTES);
		end
	endfunction

	task automatic set_config(logic [ADDR_W-1:0] ke, logic [ADDR_W-1:0] top);
		wait_drained();
		write_reg(CFG_KERNEL_END, ke);
		write_reg(CFG_PHYS_TOP, top);
		refresh_pool();
	endtask

	task automatic random_phase(int n);
		int          sel;
		logic [31:0] pick;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			pick = page_pool[$urandom_range(0, page_pool.size() - 1)];
			if (sel < 45) begin
				send(CMD_ALLOC, $urandom());
			end else if (sel < 85) begin
				send(CMD_FREE, pick);
			end else begin
				case ($urandom_range(0, 3))
					0: send(CMD_FREE, $urandom());
					1: send(CMD_FREE, pick | $urandom_range(1, PAGE_BYTES - 1));
					2: send(CMD_FREE, (32'(kernel_end_r) & ~OFFSET_MASK) - PAGE_BYTES);
					default: send(CMD_FREE,
						((32'(phys_top_r) + OFFSET_MASK) & ~OFFSET_MASK) |
						(32'($urandom_range(0, 63)) << 26));
				endcase
			end
		end
	endtask

	initial begin : stimulus
		logic [31:0] fill_page;
		logic [31:0] other_page;
		for (int i = 0; i < NUM_PAGES; i++)
			ref_cnt[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		refresh_pool();

		// reset configuration
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_FREE, 32'h0040_0000);
		send(CMD_FREE, 32'h03FF_F000);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_FREE, 32'h03FF_F000);
		send(CMD_FREE, 32'h03FF_F000);
		send(CMD_ALLOC, 32'hFFFF_FFFF);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_FREE, 32'h003F_F000);
		send(CMD_FREE, 32'h0400_0000);
		send(CMD_FREE, 32'h0040_0001);
		send(CMD_FREE, 32'h0040_0800);
		send(CMD_FREE, 32'hFFFF_FFFF);
		send(CMD_FREE, 32'hFFFF_F000);
		send(CMD_FREE, 32'h0000_0000);
		random_phase(150);

		set_config('0, 27'h4000000);
		send(CMD_FREE, 32'h0000_0000);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_FREE, 32'h0000_0000);
		random_phase(150);

		set_config(ADDR_W'($urandom_range(1, 8000) * PAGE_BYTES), '0);
		write_reg(CFG_PHYS_TOP, kernel_end_r + ADDR_W'($urandom_range(1, 4000) * PAGE_BYTES));
		refresh_pool();
		random_phase(150);

		set_config(ADDR_W'($urandom_range(0, 32'h2000000)),
			ADDR_W'($urandom_range(32'h2000000, 32'h4000000)));
		random_phase(150);

		set_config(27'h4000000, 27'h4000000);
		random_phase(60);

		set_config('0, '0);
		random_phase(60);

		set_config(27'h3FFF000, 27'h4000000);
		random_phase(100);

		set_config(KERNEL_END_RESET, PHYS_TOP_RESET);
		random_phase(130);

		// duplicate pushes of one page
		set_config('0, 27'h4000000);
		wait_drained();
		fill_page = page_pool[2];
		other_page = page_pool[3] ^ PAGE_BYTES;
		repeat (3)
			send(CMD_FREE, fill_page);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_FREE, other_page);
		send(CMD_FREE, fill_page);
		send(CMD_FREE, fill_page);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_ALLOC, 32'h0000_0000);
		send(CMD_FREE, other_page);
		send(CMD_FREE, other_page);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
